>>> rtl/core/clu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clu_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 68;
  localparam int unsigned DIV_QW = 33;

  // Parameter defaults and register reset
  localparam int unsigned DEF_MAX_ORDER = 8;
  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam logic [CFG_W-1:0] MSZ_RST  = 4'd8;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  // Clamp the wide accumulator to the signed 64-bit range
  function automatic logic [PROD_W-1:0] clamp64(input logic [ACC_W-1:0] a);
    logic [PROD_W-1:0] r;
    if ((&a[ACC_W-1:PROD_W-1]) || (~|a[ACC_W-1:PROD_W-1])) begin
      r = a[PROD_W-1:0];
    end else if (a[ACC_W-1]) begin
      r = {1'b1, {(PROD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(PROD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a signed 64-bit value to 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic [PROD_W-1:0] a);
    logic [DATA_W-1:0] r;
    if ((&a[PROD_W-1:DATA_W-1]) || (~|a[PROD_W-1:DATA_W-1])) begin
      r = a[DATA_W-1:0];
    end else if (a[PROD_W-1]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/clu_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module clu_mem #(
  parameter int unsigned AW = 6
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire [AW-1:0]               waddr_i,
  input  wire [clu_pkg::DATA_W-1:0]  wdata_i,
  input  wire [AW-1:0]               raddr_a_i,
  input  wire [AW-1:0]               raddr_b_i,
  output logic [clu_pkg::DATA_W-1:0] rdata_a_o,
  output logic [clu_pkg::DATA_W-1:0] rdata_b_o
);
  import clu_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rda_q, rdb_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two words, registered
  always_ff @(posedge clk_i) begin
    rda_q <= mem_q[raddr_a_i];
    rdb_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rda_q;
  assign rdata_b_o = rdb_q;

endmodule

`default_nettype wire

>>> rtl/core/clu_div.sv
`timescale 1ns / 1ps
`default_nettype none

module clu_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [clu_pkg::PROD_W-1:0]  num_i,
  input  wire [clu_pkg::DATA_W-1:0]  den_i,
  output logic                       done_o,
  output logic [clu_pkg::DATA_W-1:0] quot_o
);
  import clu_pkg::*;

  localparam int unsigned CW = $clog2(DIV_QW);

  logic              run_q, done_q, neg_q, big_q;
  logic [CW-1:0]     cnt_q;
  logic [DIV_QW-1:0] rem_q, sh_q, q_q;
  logic [DATA_W-1:0] d_q;
  logic [PROD_W-1:0] nmag;
  logic [DATA_W-1:0] dmag;
  logic              big;
  logic [DIV_QW-1:0] trial;
  logic              ge;

  // Magnitudes and early overflow test
  assign nmag  = num_i[PROD_W-1] ? (~num_i + PROD_W'(1)) : num_i;
  assign dmag  = den_i[DATA_W-1] ? (~den_i + DATA_W'(1)) : den_i;
  assign big   = {1'b0, nmag} >= {dmag, {DIV_QW{1'b0}}};
  assign trial = {rem_q[DIV_QW-2:0], sh_q[DIV_QW-1]};
  assign ge    = trial >= {1'b0, d_q};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= !big;
        done_q <= big;
        cnt_q <= CW'(DIV_QW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[PROD_W-1] ^ den_i[DATA_W-1];
      big_q <= big;
      d_q   <= dmag;
      rem_q <= DIV_QW'(nmag[PROD_W-1:DIV_QW]);
      sh_q  <= nmag[DIV_QW-1:0];
      q_q   <= '0;
    end else if (run_q) begin
      rem_q <= ge ? (trial - {1'b0, d_q}) : trial;
      sh_q  <= {sh_q[DIV_QW-2:0], 1'b0};
      q_q   <= {q_q[DIV_QW-2:0], ge};
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (neg_q) begin
      if (big_q || (q_q > {1'b0, S32_MIN})) begin
        quot_o = S32_MIN;
      end else begin
        quot_o = ~q_q[DATA_W-1:0] + DATA_W'(1);
      end
    end else begin
      if (big_q || (q_q > {1'b0, S32_MAX})) begin
        quot_o = S32_MAX;
      end else begin
        quot_o = q_q[DATA_W-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/core/crout_lu_decomposition_unit.sv
// Crout LU factorization unit.
// Load: write the order n (1..MAX_ORDER) with matrix_size_we_i/matrix_size_i
// while idle, then feed n*n words of the matrix in row-major order, one per
// cycle with start_i, whenever busy_o is low. A size write drops a partial load.
// After the last word busy_o rises and the matrix is factored in place in a
// dual-read, single-write store. Each factor entry makes min(r,c)+1 reads,
// then drains the multiply/accumulate pipeline; each U entry with a nonzero
// pivot then passes through the bit-serial divider, and with a zero pivot
// it is stored as zero. After the pass, n*n result words follow, one per
// cycle on result_valid_o, row-major, with last_result_o on the final one.
// The receiver cannot stall: each word is valid for exactly one cycle.
// Reset returns the order to 8, clears the load count and goes idle.
`timescale 1ns / 1ps
`default_nettype none

module crout_lu_decomposition_unit #(
  parameter int unsigned MAX_ORDER = clu_pkg::DEF_MAX_ORDER,
  parameter int unsigned FRAC_BITS = clu_pkg::DEF_FRAC_BITS
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire [clu_pkg::DATA_W-1:0]  element_value_i,
  input  wire                        matrix_size_we_i,
  input  wire [clu_pkg::CFG_W-1:0]   matrix_size_i,
  output logic                       result_valid_o,
  output logic [clu_pkg::IDX_W-1:0]  out_row_o,
  output logic [clu_pkg::IDX_W-1:0]  out_col_o,
  output logic [clu_pkg::DATA_W-1:0] factor_value_o,
  output logic                       singular_o,
  output logic                       last_result_o
);
  import clu_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ORDER);
  localparam int unsigned AW = 2 * RW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_DRAIN = 6'b000100,
    S_FIN   = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] msz_q;
  logic [RW-1:0]    nm1;
  logic [RW-1:0]    ld_r_q, ld_c_q;
  logic [RW-1:0]    r_q, c_q, p_q, k_q;
  logic [RW-1:0]    er_q, ec_q;
  logic [RW-1:0]    nxt_r, nxt_c, nxt_p;
  logic             fact_done;
  logic             is_lower;

  logic              iss_vld_q, iss_elem_q;
  logic              term_vld_q, term_elem_q;
  logic signed [PROD_W-1:0] term_q;
  logic signed [PROD_W-1:0] mul;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_rnd;
  logic [PROD_W-1:0] l_clamp;
  logic signed [PROD_W-1:0] l_shift;
  logic [DATA_W-1:0] l_val;
  logic [DATA_W-1:0] piv_q;
  logic              sing_q;

  logic              em_vld_q, em_last_q;
  logic [RW-1:0]     em_row_q, em_col_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_ra, mem_rb;
  logic [DATA_W-1:0] mem_wdata, mem_rda, mem_rdb;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_quot;

  // Effective order minus one
  always_comb begin
    if (msz_q == '0) begin
      nm1 = '0;
    end else if (32'(msz_q) > MAX_ORDER) begin
      nm1 = RW'(MAX_ORDER - 1);
    end else begin
      nm1 = RW'(msz_q - CFG_W'(1));
    end
  end

  // Crout order: column p downward, then row p rightward
  assign is_lower = (c_q == p_q);
  always_comb begin
    nxt_r     = r_q;
    nxt_c     = c_q;
    nxt_p     = p_q;
    fact_done = 1'b0;
    if (is_lower) begin
      if (r_q != nm1) begin
        nxt_r = r_q + RW'(1);
      end else if (p_q != nm1) begin
        nxt_r = p_q;
        nxt_c = p_q + RW'(1);
      end else begin
        fact_done = 1'b1;
      end
    end else begin
      if (c_q != nm1) begin
        nxt_c = c_q + RW'(1);
      end else begin
        nxt_p = p_q + RW'(1);
        nxt_r = p_q + RW'(1);
        nxt_c = p_q + RW'(1);
      end
    end
  end

  // Finish a lower entry: round, clamp, scale down, saturate
  assign acc_rnd = acc_q + (ACC_W'(1) << (FRAC_BITS - 1));
  assign l_clamp = clamp64(acc_rnd);
  assign l_shift = $signed(l_clamp) >>> FRAC_BITS;
  assign l_val   = sat32(l_shift);

  // Store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {r_q, c_q};
    mem_wdata = div_quot;
    mem_ra    = {r_q, c_q};
    mem_rb    = {k_q, c_q};
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        mem_we    = start_i;
        mem_waddr = {ld_r_q, ld_c_q};
        mem_wdata = element_value_i;
      end
      S_ISSUE: begin
        if (k_q != p_q) begin
          mem_ra = {r_q, k_q};
        end
      end
      S_FIN: begin
        if (is_lower) begin
          mem_we    = 1'b1;
          mem_wdata = l_val;
        end else if (piv_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        mem_we = div_done;
      end
      S_EMIT: begin
        mem_ra = {er_q, ec_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && (ld_r_q == nm1) && (ld_c_q == nm1)) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (k_q == p_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!iss_vld_q && !term_vld_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (div_start) begin
          state_d = S_DIV;
        end else begin
          state_d = fact_done ? S_EMIT : S_ISSUE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = fact_done ? S_EMIT : S_ISSUE;
        end
      end
      S_EMIT: begin
        if ((er_q == nm1) && (ec_q == nm1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      msz_q      <= MSZ_RST;
      ld_r_q     <= '0;
      ld_c_q     <= '0;
      r_q        <= '0;
      c_q        <= '0;
      p_q        <= '0;
      k_q        <= '0;
      er_q       <= '0;
      ec_q       <= '0;
      iss_vld_q  <= 1'b0;
      term_vld_q <= 1'b0;
      em_vld_q   <= 1'b0;
      sing_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_vld_q  <= (state_q == S_ISSUE);
      term_vld_q <= iss_vld_q;
      em_vld_q   <= (state_q == S_EMIT);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (ld_c_q != nm1) begin
              ld_c_q <= ld_c_q + RW'(1);
            end else begin
              ld_c_q <= '0;
              ld_r_q <= (ld_r_q == nm1) ? '0 : ld_r_q + RW'(1);
            end
            r_q    <= '0;
            c_q    <= '0;
            p_q    <= '0;
            k_q    <= '0;
            sing_q <= 1'b0;
          end
        end
        S_ISSUE: begin
          if (k_q != p_q) begin
            k_q <= k_q + RW'(1);
          end
        end
        S_FIN, S_DIV: begin
          if (state_d != state_q) begin
            if (is_lower && (r_q == c_q) && (l_val == '0) && (state_q == S_FIN)) begin
              sing_q <= 1'b1;
            end
            if (state_d != S_DIV) begin
              r_q  <= nxt_r;
              c_q  <= nxt_c;
              p_q  <= nxt_p;
              k_q  <= '0;
              er_q <= '0;
              ec_q <= '0;
            end
          end
        end
        S_EMIT: begin
          if (ec_q != nm1) begin
            ec_q <= ec_q + RW'(1);
          end else begin
            ec_q <= '0;
            er_q <= er_q + RW'(1);
          end
        end
        default: begin
          k_q <= '0;
        end
      endcase
      // Size write restarts the load
      if (matrix_size_we_i) begin
        msz_q  <= matrix_size_i;
        ld_r_q <= '0;
        ld_c_q <= '0;
      end
    end
  end

  // Multiply stage, registered before accumulation
  assign mul = $signed(mem_rda) * $signed(mem_rdb);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    iss_elem_q  <= (k_q == p_q);
    term_elem_q <= iss_elem_q;
    term_q      <= iss_elem_q ? (PROD_W'($signed(mem_rda)) <<< FRAC_BITS) : mul;
    if ((state_q == S_ISSUE) && (k_q == '0)) begin
      acc_q <= '0;
    end else if (term_vld_q) begin
      acc_q <= term_elem_q ? (acc_q + ACC_W'(term_q)) : (acc_q - ACC_W'(term_q));
    end
    if ((state_q == S_FIN) && is_lower && (r_q == c_q)) begin
      piv_q <= l_val;
    end
    em_row_q  <= er_q;
    em_col_q  <= ec_q;
    em_last_q <= (er_q == nm1) && (ec_q == nm1);
  end

  clu_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_ra),
    .raddr_b_i (mem_rb),
    .rdata_a_o (mem_rda),
    .rdata_b_o (mem_rdb)
  );

  clu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (clamp64(acc_q)),
    .den_i   (piv_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Drive result word
  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = em_vld_q;
  assign out_row_o      = IDX_W'(em_row_q);
  assign out_col_o      = IDX_W'(em_col_q);
  assign factor_value_o = mem_rda;
  assign singular_o     = sing_q;
  assign last_result_o  = em_vld_q && em_last_q;

  a_valid_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_EMIT))
    else $error("result word without read");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside divide");

  a_no_write_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE || state_q == S_DRAIN) |-> !mem_we)
    else $error("store written during accumulation");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |=> !result_valid_o)
    else $error("word after last");

endmodule

`default_nettype wire
